// ===== hdl/tlv_stream_parser_core_assert.svh =====
// Assertion macros for the TLV stream parser.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TLV_STREAM_PARSER_CORE_ASSERT_SVH
`define TLV_STREAM_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check on every rising clock edge, switched off while reset is applied
`define TLVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tlvp check failed");
// Same check, with a message of the caller's choosing
`define TLVP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define TLVP_ASSERT(lbl, prop)
`define TLVP_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ===== hdl/tlvp_pkg.sv =====
// Shared types and constants of the TLV stream parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package tlvp_pkg;

  // Width of a decoded length and the byte limit for continuation lengths
  localparam int unsigned LEN_W         = 28;
  localparam int unsigned MAX_LEN_BYTES = 4;
  localparam logic [LEN_W-1:0] LEN_MAX  = '1;

  // Classification of each byte
  typedef enum logic [1:0] {
    KIND_TAG = 2'd0,
    KIND_LEN = 2'd1,
    KIND_VAL = 2'd2,
    KIND_IGN = 2'd3
  } kind_e;

  // Block status, reported on the final byte
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TAG      = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_e;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    kind_e            byte_kind;
    logic [7:0]       tag;
    logic [7:0]       value_byte;
    logic [LEN_W-1:0] field_length;
    logic             element_end;
    logic             block_done;
    err_e             status;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/tlv_stream_parser_core.sv =====
// TLV stream parser: one result item per input byte; an accepted byte passes the input
// register and the decode step into the output register. Throughput is one item per cycle while
// the output is not stalled; a stalled result holds the decode step and then the input.
// Reset (rst_ni low, asynchronous) empties both registers, sets the length format to
// 0 and puts the parser at the start of a block.
// Built from tlvp_in_stage and tlvp_decoder; types from tlvp_pkg.
`default_nettype none

module tlv_stream_parser_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_length_format_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       block_end_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 byte_kind_o,
  output logic [7:0]                 tag_o,
  output logic [7:0]                 value_byte_o,
  output logic [tlvp_pkg::LEN_W-1:0] field_length_o,
  output logic                       element_end_o,
  output logic                       block_done_o,
  output logic [1:0]                 status_o
);
  import tlvp_pkg::*;

  `include "tlv_stream_parser_core_assert.svh"

  logic     length_format_q;
  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     step;
  result_t  result;
  result_t  out_q;
  logic     out_valid_q;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_format_q <= 1'b0;
    end else if (cfg_valid_i) begin
      length_format_q <= cfg_length_format_i;
    end
  end

  assign in_item.data_byte = data_byte_i;
  assign in_item.block_end = block_end_i;

  // Decode one item when the output register has room
  assign step = s1_valid && (!out_valid_q || out_ready_i);

  tlvp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  tlvp_decoder u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .length_format_i (length_format_q),
    .item_i          (s1_item),
    .result_o        (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_kind_o    = out_q.byte_kind;
  assign tag_o          = out_q.tag;
  assign value_byte_o   = out_q.value_byte;
  assign field_length_o = out_q.field_length;
  assign element_end_o  = out_q.element_end;
  assign block_done_o   = out_q.block_done;
  assign status_o       = out_q.status;

  // Status is only reported on the final byte of a block
  `TLVP_ASSERT_MSG(a_status_on_done,
                   (out_valid_o && !block_done_o) |-> (status_o == ERR_NONE),
                   "status set outside block end")
  // Value byte is zero unless the byte is a value byte
  `TLVP_ASSERT(a_value_zero, (out_valid_o && (byte_kind_o != KIND_VAL)) |-> (value_byte_o == 8'h00))
  // An element can only end on a length or value byte
  `TLVP_ASSERT(a_end_kind,
               (out_valid_o && element_end_o) |->
               ((byte_kind_o == KIND_LEN) || (byte_kind_o == KIND_VAL)))

endmodule

`default_nettype wire

// ===== hdl/tlvp_in_stage.sv =====
// Input register of the TLV stream parser: holds one item for the decode step.
// Depends on tlvp_pkg for the item type.
`default_nettype none

module tlvp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlvp_pkg::in_item_t item_i,
  input  logic              take_i,
  output logic              valid_o,
  output tlvp_pkg::in_item_t item_o
);
  import tlvp_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Room when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hdl/tlvp_decoder.sv =====
// Per-byte decode of the TLV stream: parse state and the next-state logic.
// Depends on tlvp_pkg and the assertion macro header.
`default_nettype none

module tlvp_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              length_format_i,
  input  tlvp_pkg::in_item_t item_i,
  output tlvp_pkg::result_t  result_o
);
  import tlvp_pkg::*;

  `include "tlv_stream_parser_core_assert.svh"

  localparam int unsigned NEXT_W = LEN_W + 7;

  // Parse phase codes
  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;
  localparam logic [1:0] PH_IGN = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic             first_q, first_d;
  logic [7:0]       tag_q, tag_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  err_e             err_q, err_d;

  logic [7:0]       b;
  logic             last;
  logic [2:0]       cnt_inc;
  logic [NEXT_W-1:0] len_next;
  logic             more;
  logic             ovf;
  logic [LEN_W-1:0] rem_dec;
  logic             set_err;
  err_e             err_code;
  logic             bad_tag;

  assign b    = item_i.data_byte;
  assign last = item_i.block_end;

  // Length byte count saturates at seven
  assign cnt_inc = (cnt_q < 3'd7) ? cnt_q + 3'd1 : cnt_q;

  // Candidate length after this byte, for both formats
  always_comb begin
    if (!length_format_i) begin
      more     = b[7];
      len_next = (cnt_inc == 3'd1) ? NEXT_W'(b[6:0]) : {acc_q, b[6:0]};
    end else begin
      more     = (b == 8'hFF);
      len_next = (cnt_inc == 3'd1) ? NEXT_W'(b) : NEXT_W'(acc_q) + NEXT_W'(b);
    end
  end

  assign ovf     = len_next > NEXT_W'(LEN_MAX);
  assign rem_dec = (rem_q != '0) ? rem_q - LEN_W'(1) : rem_q;

  // Tag placement rule
  assign bad_tag = length_format_i ? ((b == 8'h00) && !first_q)
                                   : ((b == 8'h00) != first_q);

  // Next state and result
  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    tag_d    = tag_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    err_d    = err_q;
    set_err  = 1'b0;
    err_code = ERR_NONE;
    result_o = '0;
    result_o.byte_kind = KIND_IGN;

    case (phase_q)
      PH_TAG: begin
        // a lone tag byte that ends the block is ignored
        if (!last) begin
          result_o.byte_kind = KIND_TAG;
          tag_d   = b;
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PH_LEN;
          first_d = 1'b0;
          if (bad_tag) begin
            set_err  = 1'b1;
            err_code = ERR_TAG;
          end
        end
      end
      PH_LEN: begin
        result_o.byte_kind = KIND_LEN;
        cnt_d = cnt_inc;
        if (ovf) begin
          acc_d    = LEN_MAX;
          set_err  = 1'b1;
          err_code = ERR_OVERFLOW;
        end else begin
          acc_d = len_next[LEN_W-1:0];
          if (more) begin
            if (!length_format_i && (cnt_inc >= 3'(MAX_LEN_BYTES))) begin
              set_err  = 1'b1;
              err_code = ERR_OVERFLOW;
            end else if (last) begin
              set_err  = 1'b1;
              err_code = ERR_TRUNC;
            end
          end else if (len_next[LEN_W-1:0] == '0) begin
            result_o.element_end = 1'b1;
            phase_d = PH_TAG;
          end else begin
            rem_d   = len_next[LEN_W-1:0];
            phase_d = PH_VAL;
            if (last) begin
              set_err  = 1'b1;
              err_code = ERR_TRUNC;
            end
          end
        end
      end
      PH_VAL: begin
        result_o.byte_kind  = KIND_VAL;
        result_o.value_byte = b;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          result_o.element_end = 1'b1;
          phase_d = PH_TAG;
        end else if (last) begin
          set_err  = 1'b1;
          err_code = ERR_TRUNC;
        end
      end
      default: ;
    endcase

    // Only the first error of a block is kept
    if (set_err) begin
      if (err_q == ERR_NONE) begin
        err_d = err_code;
      end
      phase_d = PH_IGN;
    end

    result_o.tag          = tag_d;
    result_o.field_length = acc_d;
    result_o.block_done   = last;
    result_o.status       = last ? err_d : ERR_NONE;

    // Final byte: back to the start of a new block
    if (last) begin
      phase_d = PH_TAG;
      first_d = 1'b1;
      tag_d   = '0;
      acc_d   = '0;
      cnt_d   = '0;
      rem_d   = '0;
      err_d   = ERR_NONE;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      first_q <= 1'b1;
      tag_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
      tag_q   <= tag_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

  // A value phase always has bytes left to come
  `TLVP_ASSERT(a_val_rem_nonzero, (phase_q == PH_VAL) |-> (rem_q != '0))
  // The final byte of a block leaves the parser ready for a fresh block
  `TLVP_ASSERT(a_block_restart,
               (step_i && last) |=> ((phase_q == PH_TAG) && first_q && (err_q == ERR_NONE)))

endmodule

`default_nettype wire
